// File: hdl/rtef_pkg.sv
// ----------------------------------------------------------------------------
// rtef_pkg
// Types, codes and constants shared by the RS485 transmit echo filter.
// ----------------------------------------------------------------------------
package rtef_pkg;

    localparam int unsigned MIN_ARM_LEN = 4;
    localparam int unsigned DROP_MIN    = 3;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic [15:0] TIMEOUT_RST = 16'd50;

    typedef enum logic [1:0] {
        ACT_TX   = 2'd0,
        ACT_RX   = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_FWD  = 2'd0,
        KIND_ECHO = 2'd1,
        KIND_DROP = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_CODES_LO = 2'd0,
        CFG_CODES_HI = 2'd1,
        CFG_TIMEOUT  = 2'd2
    } t_cfg;

    typedef enum logic [1:0] {
        SRC_MEM   = 2'd0,
        SRC_EVENT = 2'd1,
        SRC_BYTE  = 2'd2
    } t_src;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FRD,
        ST_FOUT,
        ST_EVENT,
        ST_TAIL
    } t_state;

    // results owed for one item, emitted in the order flush, event, tail
    typedef struct packed {
        logic  flush;
        logic  ev;
        t_kind ev_kind;
        logic  tail;
    } t_plan;

    typedef struct packed {
        t_plan plan;
        logic  flush_last;
        logic  out_free;
    } t_dp_status;

    typedef struct packed {
        logic  accept;
        logic  exec;
        logic  rd_flush;
        logic  emit;
        t_src  emit_src;
        t_kind emit_kind;
        logic  emit_last;
    } t_dp_cmd;

    function automatic logic code_on(input logic [7:0] code,
                                     input logic [63:0] lo,
                                     input logic [63:0] hi);
        logic r;
        if (code[7]) begin
            r = 1'b0;
        end else if (code[6]) begin
            r = hi[code[5:0]];
        end else begin
            r = lo[code[5:0]];
        end
        return r;
    endfunction

endpackage

// File: hdl/rs485_tx_echo_filter.sv
// ----------------------------------------------------------------------------
// rs485_tx_echo_filter
// Local echo suppression for a half-duplex RS485 transceiver.
// ----------------------------------------------------------------------------
// An item that causes no result (transmit byte, plain tick) returns the
// sequencer to idle after its update; each byte forwarded from the held
// prefix is first read out of the frame store through its registered read
// port and then loaded into the output register. A stalled output holds
// the sequencer. The frame store has no reset: only bytes of the current
// frame are ever read back.
module rs485_tx_echo_filter #(
    parameter int MAX_FRAME = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic        o_last,
    output logic [31:0] o_echo_count,
    output logic [31:0] o_drop_count,
    output logic [31:0] o_mismatch_count
);
    import rtef_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    rtef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_ready (o_in_ready)
    );

    rtef_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_data_byte      (i_data_byte),
        .i_frame_end      (i_frame_end),
        .i_out_ready      (i_out_ready),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_kind           (o_kind),
        .o_last           (o_last),
        .o_echo_count     (o_echo_count),
        .o_drop_count     (o_drop_count),
        .o_mismatch_count (o_mismatch_count)
    );

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> dp_status.out_free)
        else $error("result loaded over an untaken result");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (dp_cmd.exec && !o_in_ready))
        else $error("accepted item not executed next cycle");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.emit && dp_cmd.emit_last) |=> o_in_ready)
        else $error("sequencer busy after final result");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!dp_cmd.emit && !dp_cmd.exec))
        else $error("activity while waiting for an item");

endmodule

// File: hdl/rtef_datapath.sv
// ----------------------------------------------------------------------------
// rtef_datapath
// Frame store, match state, counters, configuration and output register.
// ----------------------------------------------------------------------------
module rtef_datapath #(
    parameter int MAX_FRAME = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic [1:0]           i_action,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_frame_end,
    input  logic                 i_out_ready,
    input  rtef_pkg::t_dp_cmd    i_cmd,
    output rtef_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_kind,
    output logic                 o_last,
    output logic [31:0]          o_echo_count,
    output logic [31:0]          o_drop_count,
    output logic [31:0]          o_mismatch_count
);
    import rtef_pkg::*;

    localparam int LW = $clog2(MAX_FRAME + 1);
    localparam int AW = $clog2(MAX_FRAME);

    logic [7:0]    r_mem [MAX_FRAME];
    logic [7:0]    r_rd;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;

    logic [63:0]   r_codes_lo, r_codes_hi;
    logic [15:0]   r_timeout;

    t_action       r_act;
    logic [7:0]    r_byte;
    logic          r_end;

    logic [LW-1:0] r_frame_len, n_frame_len;
    logic [LW-1:0] r_matched, n_matched;
    logic          r_active, n_active;
    logic          r_tx_loading, n_tx_loading;
    logic          r_overlong, n_overlong;
    logic [16:0]   r_elapsed, n_elapsed;
    logic [31:0]   r_echo, n_echo;
    logic [31:0]   r_drop, n_drop;
    logic [31:0]   r_mism, n_mism;
    logic [7:0]    r_code, n_code;
    logic [LW-1:0] r_fcnt;
    logic [AW-1:0] r_fidx;

    logic [LW-1:0] len_eff;
    logic          ovl_eff;
    logic [7:0]    code_eff;
    logic [16:0]   el_new;
    t_plan         plan;

    logic          r_ovalid;
    logic [7:0]    r_obyte;
    t_kind         r_okind;
    logic          r_olast;
    logic [31:0]   r_oecho, r_odrop, r_omism;

    // frame store
    assign rd_addr = i_cmd.rd_flush ? r_fidx : r_matched[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= r_byte;
        end
        r_rd <= r_mem[rd_addr];
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes_lo <= '0;
            r_codes_hi <= '0;
            r_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CODES_LO: begin
                    r_codes_lo <= i_cfg_data;
                end
                CFG_CODES_HI: begin
                    r_codes_hi <= i_cfg_data;
                end
                CFG_TIMEOUT: begin
                    r_timeout <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // item decode and state update
    always_comb begin
        n_frame_len  = r_frame_len;
        n_matched    = r_matched;
        n_active     = r_active;
        n_tx_loading = r_tx_loading;
        n_overlong   = r_overlong;
        n_elapsed    = r_elapsed;
        n_echo       = r_echo;
        n_drop       = r_drop;
        n_mism       = r_mism;
        n_code       = r_code;
        len_eff      = r_frame_len;
        ovl_eff      = r_overlong;
        code_eff     = r_code;
        el_new       = (r_elapsed != ELAPSED_MAX) ? r_elapsed + 17'd1 : r_elapsed;
        plan         = '0;
        mem_we       = 1'b0;
        mem_wa       = r_frame_len[AW-1:0];
        if (i_cmd.exec) begin
            unique case (r_act)
                ACT_TX: begin
                    if (!r_tx_loading) begin
                        len_eff      = '0;
                        ovl_eff      = 1'b0;
                        n_matched    = '0;
                        n_active     = 1'b0;
                        n_tx_loading = 1'b1;
                    end
                    if (len_eff < LW'(MAX_FRAME)) begin
                        mem_we      = 1'b1;
                        mem_wa      = len_eff[AW-1:0];
                        n_frame_len = len_eff + LW'(1);
                        if (len_eff == LW'(1)) begin
                            code_eff = r_byte;
                        end
                    end else begin
                        n_frame_len = len_eff;
                        ovl_eff     = 1'b1;
                    end
                    n_overlong = ovl_eff;
                    n_code     = code_eff;
                    if (r_end) begin
                        n_tx_loading = 1'b0;
                        n_matched    = '0;
                        if (!ovl_eff && n_frame_len >= LW'(MIN_ARM_LEN) &&
                            code_on(code_eff, r_codes_lo, r_codes_hi)) begin
                            n_active  = 1'b1;
                            n_elapsed = '0;
                        end
                    end
                end
                ACT_RX: begin
                    if (!r_active) begin
                        plan.tail = 1'b1;
                    end else if (r_elapsed > {1'b0, r_timeout}) begin
                        plan.tail = 1'b1;
                        if (r_matched != '0) begin
                            n_active  = 1'b0;
                            n_matched = '0;
                            if (r_matched >= LW'(DROP_MIN)) begin
                                n_drop       = r_drop + 32'd1;
                                plan.ev      = 1'b1;
                                plan.ev_kind = KIND_DROP;
                            end else begin
                                plan.flush = 1'b1;
                            end
                        end
                    end else if (r_matched < r_frame_len && r_byte == r_rd) begin
                        n_matched = r_matched + LW'(1);
                        if (n_matched == r_frame_len) begin
                            n_echo       = r_echo + 32'd1;
                            n_matched    = '0;
                            n_active     = 1'b0;
                            plan.ev      = 1'b1;
                            plan.ev_kind = KIND_ECHO;
                        end
                    end else begin
                        n_mism     = r_mism + 32'd1;
                        n_matched  = '0;
                        n_active   = 1'b0;
                        plan.flush = (r_matched != '0);
                        plan.tail  = 1'b1;
                    end
                end
                ACT_TICK: begin
                    n_elapsed = el_new;
                    if (r_active && r_matched != '0 && el_new > {1'b0, r_timeout}) begin
                        n_active  = 1'b0;
                        n_matched = '0;
                        if (r_matched >= LW'(DROP_MIN)) begin
                            n_drop       = r_drop + 32'd1;
                            plan.ev      = 1'b1;
                            plan.ev_kind = KIND_DROP;
                        end else begin
                            plan.flush = 1'b1;
                        end
                    end
                end
                ACT_NONE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len  <= '0;
            r_matched    <= '0;
            r_active     <= 1'b0;
            r_tx_loading <= 1'b0;
            r_overlong   <= 1'b0;
            r_elapsed    <= '0;
            r_echo       <= '0;
            r_drop       <= '0;
            r_mism       <= '0;
        end else begin
            r_frame_len  <= n_frame_len;
            r_matched    <= n_matched;
            r_active     <= n_active;
            r_tx_loading <= n_tx_loading;
            r_overlong   <= n_overlong;
            r_elapsed    <= n_elapsed;
            r_echo       <= n_echo;
            r_drop       <= n_drop;
            r_mism       <= n_mism;
        end
    end

    // input capture, held prefix walk
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        if (i_cmd.accept) begin
            r_act  <= t_action'(i_action);
            r_byte <= i_data_byte;
            r_end  <= i_frame_end;
        end
        if (i_cmd.exec) begin
            r_fcnt <= r_matched;
            r_fidx <= '0;
        end else if (i_cmd.emit && i_cmd.emit_src == SRC_MEM) begin
            r_fidx <= r_fidx + AW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            unique case (i_cmd.emit_src)
                SRC_MEM:   r_obyte <= r_rd;
                SRC_BYTE:  r_obyte <= r_byte;
                default:   r_obyte <= '0;
            endcase
            r_okind <= i_cmd.emit_kind;
            r_olast <= i_cmd.emit_last;
            r_oecho <= r_echo;
            r_odrop <= r_drop;
            r_omism <= r_mism;
        end
    end

    assign o_status.plan       = plan;
    assign o_status.flush_last = ((LW'(r_fidx) + LW'(1)) == r_fcnt);
    assign o_status.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid      = r_ovalid;
    assign o_out_byte       = r_obyte;
    assign o_kind           = r_okind;
    assign o_last           = r_olast;
    assign o_echo_count     = r_oecho;
    assign o_drop_count     = r_odrop;
    assign o_mismatch_count = r_omism;

endmodule

// File: hdl/rtef_ctrl.sv
// ----------------------------------------------------------------------------
// rtef_ctrl
// Sequencer: accepts an item, runs its update, then emits its results.
// ----------------------------------------------------------------------------
module rtef_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  rtef_pkg::t_dp_status i_status,
    output rtef_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_ready
);
    import rtef_pkg::*;

    t_state r_state, n_state;
    t_plan  r_plan, n_plan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_plan  <= '0;
        end else begin
            r_state <= n_state;
            r_plan  <= n_plan;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_plan     = r_plan;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_plan     = i_status.plan;
                priority if (i_status.plan.flush) begin
                    n_state = ST_FRD;
                end else if (i_status.plan.ev) begin
                    n_state = ST_EVENT;
                end else if (i_status.plan.tail) begin
                    n_state = ST_TAIL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FRD: begin
                o_cmd.rd_flush = 1'b1;
                n_state        = ST_FOUT;
            end
            ST_FOUT: begin
                o_cmd.rd_flush = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_src  = SRC_MEM;
                    o_cmd.emit_kind = KIND_FWD;
                    o_cmd.emit_last = i_status.flush_last && !r_plan.tail;
                    if (!i_status.flush_last) begin
                        n_state = ST_FRD;
                    end else if (r_plan.tail) begin
                        n_state = ST_TAIL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EVENT: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_src  = SRC_EVENT;
                    o_cmd.emit_kind = r_plan.ev_kind;
                    o_cmd.emit_last = !r_plan.tail;
                    n_state         = r_plan.tail ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_src  = SRC_BYTE;
                    o_cmd.emit_kind = KIND_FWD;
                    o_cmd.emit_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
